FILE: design/asfd_pkg.sv
// Shared types and constants for the ASF packet payload demultiplexer.
package asfd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_AUDIO  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_HEADER   = 2'd0;
  localparam logic [1:0] ERR_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_OVERRUN  = 2'd2;
  localparam logic [1:0] ERR_EOS      = 2'd3;

  // Packet start marker
  localparam logic [7:0] HDR_BYTE = 8'h82;

  // Configuration register indexes
  localparam logic REG_PKT_SIZE  = 1'b0;
  localparam logic REG_STREAM_ID = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] PKT_SIZE_RST  = 16'd4096;
  localparam logic [6:0]  STREAM_ID_RST = 7'd1;

  // Classified input transaction
  typedef struct packed {
    logic       is_eos;
    logic [7:0] data;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [15:0] length;
    logic [1:0]  code;
  } result_t;

endpackage

FILE: design/asf_packet_payload_demux.sv
// Top level of the ASF packet payload demultiplexer with its register port.
// Takes one stream byte (or end-of-stream mark) per cycle unless stalled and
// passes out the payload bytes of the selected stream as they arrive, closing
// each packet that carried audio with an accept result carrying its audio
// byte count, or an error result that voids the bytes already passed for
// that packet; errors hold until reset. An input queue feeds the parser,
// which consumes one transaction per cycle while the result queue has room
// for two; results leave at one per cycle unless out_stall is high, so a byte
// that yields two results (last audio byte plus accept or error) takes two
// output transfers. No clearing pass is needed after reset.
module asf_packet_payload_demux #(
  parameter int unsigned MAX_PACKET_SIZE = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] audio_length,
  output logic [1:0]  error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]       pkt_size;
  logic [6:0]        audio_stream_id;
  logic              cfg_wr;
  asfd_pkg::item_t   item;
  logic              item_valid;
  logic              item_take;
  logic              room;
  logic [1:0]        push_n;
  asfd_pkg::result_t res0;
  asfd_pkg::result_t res1;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == asfd_pkg::REG_STREAM_ID) ? {25'd0, audio_stream_id}
                                                        : {16'd0, pkt_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_size        <= asfd_pkg::PKT_SIZE_RST;
      audio_stream_id <= asfd_pkg::STREAM_ID_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == asfd_pkg::REG_PKT_SIZE) pkt_size <= pwdata[15:0];
      else audio_stream_id <= pwdata[6:0];
    end
  end

  asfd_inq u_inq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .data_byte  (data_byte),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  asfd_parse #(
    .MAX_PACKET_SIZE (MAX_PACKET_SIZE)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .room        (room),
    .pkt_size    (pkt_size),
    .stream_id   (audio_stream_id),
    .push_n      (push_n),
    .res0        (res0),
    .res1        (res1)
  );

  asfd_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push_n       (push_n),
    .res0         (res0),
    .res1         (res1),
    .room         (room),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .audio_length (audio_length),
    .error_code   (error_code)
  );

endmodule

FILE: design/asfd_inq.sv
// Front end: accepts input transactions, classifies them and queues them.
module asfd_inq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            operation,
  input  logic [7:0]      data_byte,
  output asfd_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_take
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  asfd_pkg::item_t  q [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign in_stall   = (count == (AW+1)'(DEPTH));
  assign item_valid = (count != '0);
  assign item       = q[rd_ptr];
  assign push       = in_valid & ~in_stall;
  assign pop        = item_valid & item_take;

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // storage, with end-of-stream marked as its own class
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].is_eos <= operation;
      q[wr_ptr].data   <= data_byte;
    end
  end

endmodule

FILE: design/asfd_outq.sv
// Result queue: takes up to two results a cycle, hands one out a cycle unless stalled.
module asfd_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  asfd_pkg::result_t res0,
  input  asfd_pkg::result_t res1,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        result_kind,
  output logic [7:0]        payload_byte,
  output logic [15:0]       audio_length,
  output logic [1:0]        error_code
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  asfd_pkg::result_t q [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              pop;
  asfd_pkg::result_t head;

  // room for the worst case of two results from one transaction
  assign room      = (count <= (AW+1)'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid & ~out_stall;
  assign head      = q[rd_ptr];

  assign result_kind  = head.kind;
  assign payload_byte = head.payload;
  assign audio_length = head.length;
  assign error_code   = head.code;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push_n) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q[wr_ptr] <= res0;
    if (push_n == 2'd2) q[wr_ptr + 1'b1] <= res1;
  end

endmodule

FILE: design/asfd_parse.sv
// Back end: packet and payload parser, one byte per cycle while the result queue has room.
module asfd_parse #(
  parameter int unsigned MAX_PACKET_SIZE = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  asfd_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_take,
  input  logic              room,
  input  logic [15:0]       pkt_size,
  input  logic [6:0]        stream_id,
  output logic [1:0]        push_n,
  output asfd_pkg::result_t res0,
  output asfd_pkg::result_t res1
);

  localparam logic [3:0] PH_HDR     = 4'd0;
  localparam logic [3:0] PH_EC      = 4'd1;
  localparam logic [3:0] PH_FLAGS   = 4'd2;
  localparam logic [3:0] PH_PROP    = 4'd3;
  localparam logic [3:0] PH_LEN     = 4'd4;
  localparam logic [3:0] PH_SEQ     = 4'd5;
  localparam logic [3:0] PH_PAD     = 4'd6;
  localparam logic [3:0] PH_TIME    = 4'd7;
  localparam logic [3:0] PH_PCOUNT  = 4'd8;
  localparam logic [3:0] PH_STREAM  = 4'd9;
  localparam logic [3:0] PH_SKIPHDR = 4'd10;
  localparam logic [3:0] PH_REPLEN  = 4'd11;
  localparam logic [3:0] PH_REPDATA = 4'd12;
  localparam logic [3:0] PH_PAYLEN  = 4'd13;
  localparam logic [3:0] PH_DELTA   = 4'd14;
  localparam logic [3:0] PH_DATA    = 4'd15;

  localparam logic [1:0] LT_WORD = 2'd2;

  // 2-bit length type to byte count
  function automatic logic [3:0] len2(input logic [1:0] b);
    return (b == 2'd3) ? 4'd4 : {2'b00, b};
  endfunction

  // byte count of a fixed-layout field
  function automatic logic [3:0] flen(input logic [3:0] ph, input logic [7:0] ltf,
                                     input logic [7:0] prop);
    logic [3:0] n;
    case (ph)
      PH_EC:      n = 4'd2;
      PH_FLAGS:   n = 4'd1;
      PH_PROP:    n = 4'd1;
      PH_DELTA:   n = 4'd1;
      PH_LEN:     n = len2(ltf[6:5]);
      PH_SEQ:     n = len2(ltf[2:1]);
      PH_PAD:     n = len2(ltf[4:3]);
      PH_TIME:    n = 4'd6;
      PH_PCOUNT:  n = {3'b000, ltf[0]};
      PH_SKIPHDR: n = len2(prop[5:4]) + len2(prop[3:2]);
      PH_REPLEN:  n = len2(prop[1:0]);
      PH_PAYLEN:  n = 4'd2;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  // parser state
  logic [3:0]  phase, phase_next;
  logic [3:0]  fcnt, fcnt_next;
  logic [31:0] acc, acc_next;
  logic [7:0]  ltf, ltf_next;
  logic [7:0]  prop, prop_next;
  logic [31:0] pad, pad_next;
  logic [15:0] bleft, bleft_next;
  logic [5:0]  pleft, pleft_next;
  logic [31:0] pbl, pbl_next;
  logic        is_audio, is_audio_next;
  logic [15:0] acount, acount_next;
  logic        err, err_next;
  logic        rep_one, rep_one_next;
  logic [1:0]  lt, lt_next;

  // step working values
  logic        take;
  logic [15:0] ps;
  logic [7:0]  b;
  logic [31:0] accv;
  logic [31:0] rv;
  logic [31:0] pv;
  logic [31:0] lenv;
  logic [32:0] padsum;
  logic [4:0]  hdr;
  logic        go_complete, go_len, go_seq, go_pad, go_time, go_pcount;
  logic        go_replen, go_paylen, go_delta, go_data, go_after;
  logic        fail_req;
  logic [1:0]  fail_code;
  logic        put_audio, put_accept, put_end;
  asfd_pkg::result_t second;

  assign take      = item_valid & room;
  assign item_take = take;
  assign ps = (32'(pkt_size) > MAX_PACKET_SIZE) ? 16'(MAX_PACKET_SIZE) : pkt_size;

  // next-state logic for one byte
  always_comb begin
    phase_next = phase;  fcnt_next = fcnt;    acc_next = acc;
    ltf_next = ltf;      prop_next = prop;    pad_next = pad;
    bleft_next = bleft;  pleft_next = pleft;  pbl_next = pbl;
    is_audio_next = is_audio;  acount_next = acount;  err_next = err;
    rep_one_next = rep_one;    lt_next = lt;
    b = item.data;  accv = acc;  rv = '0;  pv = '0;  lenv = '0;  padsum = '0;  hdr = '0;
    go_complete = 1'b0; go_len = 1'b0; go_seq = 1'b0; go_pad = 1'b0; go_time = 1'b0;
    go_pcount = 1'b0; go_replen = 1'b0; go_paylen = 1'b0; go_delta = 1'b0;
    go_data = 1'b0; go_after = 1'b0;
    fail_req = 1'b0; fail_code = asfd_pkg::ERR_HEADER;
    put_audio = 1'b0; put_accept = 1'b0; put_end = 1'b0;

    if (take && !err) begin
      if (item.is_eos) begin
        if (phase == PH_HDR) put_end = 1'b1;
        else begin fail_req = 1'b1; fail_code = asfd_pkg::ERR_EOS; end
      end else begin
        if (phase >= PH_STREAM && bleft != '0) bleft_next = bleft - 1'b1;
        case (phase)
          PH_HDR: begin
            if (b != asfd_pkg::HDR_BYTE) begin
              fail_req = 1'b1; fail_code = asfd_pkg::ERR_HEADER;
            end else begin
              acount_next = '0; phase_next = PH_EC; fcnt_next = '0; acc_next = '0;
            end
          end
          PH_STREAM: begin
            is_audio_next = (b[6:0] == stream_id);
            if (bleft_next < 16'(flen(PH_SKIPHDR, ltf, prop)) + 16'(flen(PH_REPLEN, ltf, prop)))
            begin
              fail_req = 1'b1; fail_code = asfd_pkg::ERR_OVERRUN;
            end else begin
              fcnt_next = '0; acc_next = '0;
              if (flen(PH_SKIPHDR, ltf, prop) != '0) phase_next = PH_SKIPHDR;
              else if (flen(PH_REPLEN, ltf, prop) != '0) phase_next = PH_REPLEN;
              else go_replen = 1'b1;
            end
          end
          PH_REPDATA: begin
            if (pbl != '0) pbl_next = pbl - 1'b1;
            if (pbl_next == '0) go_paylen = 1'b1;
          end
          PH_DATA: begin
            if (is_audio) begin
              put_audio = 1'b1; acount_next = acount + 1'b1;
            end
            if (pbl != '0) pbl_next = pbl - 1'b1;
            if (pbl_next == '0) go_after = 1'b1;
          end
          default: begin
            // little-endian field gather
            if (fcnt < 4'd4) accv = acc | (32'(b) << {fcnt[1:0], 3'b000});
            acc_next  = accv;
            fcnt_next = fcnt + 1'b1;
            if (fcnt_next >= flen(phase, ltf, prop)) go_complete = 1'b1;
          end
        endcase
      end
    end

    // field completion
    if (go_complete) begin
      case (phase)
        PH_EC: begin phase_next = PH_FLAGS; fcnt_next = '0; acc_next = '0; end
        PH_FLAGS: begin
          ltf_next = accv[7:0]; phase_next = PH_PROP; fcnt_next = '0; acc_next = '0;
        end
        PH_PROP: begin prop_next = accv[7:0]; go_len = 1'b1; end
        PH_LEN: begin pbl_next = accv; go_seq = 1'b1; end
        PH_SEQ: go_pad = 1'b1;
        PH_PAD: begin
          pad_next = accv; phase_next = PH_TIME; fcnt_next = '0; acc_next = '0;
        end
        PH_TIME: go_time = 1'b1;
        PH_PCOUNT: begin go_pcount = 1'b1; pv = accv; end
        PH_SKIPHDR: begin
          fcnt_next = '0; acc_next = '0;
          if (flen(PH_REPLEN, ltf, prop) != '0) phase_next = PH_REPLEN;
          else go_replen = 1'b1;
        end
        PH_REPLEN: begin go_replen = 1'b1; rv = accv; end
        PH_PAYLEN: begin pbl_next = accv; go_delta = 1'b1; end
        PH_DELTA: go_data = 1'b1;
        default: ;
      endcase
    end

    // header fields that may be absent
    if (go_len) begin
      fcnt_next = '0; acc_next = '0;
      if (len2(ltf_next[6:5]) != '0) phase_next = PH_LEN;
      else begin pbl_next = '0; go_seq = 1'b1; end
    end
    if (go_seq) begin
      fcnt_next = '0; acc_next = '0;
      if (len2(ltf_next[2:1]) != '0) phase_next = PH_SEQ;
      else go_pad = 1'b1;
    end
    if (go_pad) begin
      fcnt_next = '0; acc_next = '0;
      if (len2(ltf_next[4:3]) != '0) phase_next = PH_PAD;
      else begin pad_next = '0; phase_next = PH_TIME; end
    end

    // packet length check and implicit padding
    if (go_time) begin
      lenv = (ltf_next[6:5] == 2'd0) ? 32'(ps) : pbl_next;
      if (lenv < 32'(ps)) begin
        padsum = {1'b0, pad_next} + 33'(ps - lenv[15:0]);
        pad_next = padsum[32] ? '1 : padsum[31:0];
        lenv = 32'(ps);
      end
      if (lenv > 32'(ps)) begin
        fail_req = 1'b1; fail_code = asfd_pkg::ERR_LENGTH;
      end else begin
        fcnt_next = '0; acc_next = '0;
        if (ltf_next[0]) phase_next = PH_PCOUNT;
        else go_pcount = 1'b1;
      end
    end

    // payload count and header size
    if (go_pcount) begin
      hdr = 5'd11 + 5'(len2(ltf_next[6:5])) + 5'(len2(ltf_next[2:1]))
          + 5'(len2(ltf_next[4:3])) + 5'(ltf_next[0]);
      if (ltf_next[0]) begin
        pleft_next = pv[5:0]; lt_next = pv[7:6];
      end else begin
        pleft_next = 6'd1; lt_next = LT_WORD;
      end
      if (ps < 16'(hdr)) begin
        fail_req = 1'b1; fail_code = asfd_pkg::ERR_LENGTH;
      end else begin
        bleft_next = ps - 16'(hdr); go_after = 1'b1;
      end
    end

    // replicated length
    if (go_replen) begin
      if (32'(bleft_next) < rv) begin
        fail_req = 1'b1; fail_code = asfd_pkg::ERR_OVERRUN;
      end else begin
        rep_one_next = (rv == 32'd1);
        pbl_next = rv;
        if (rv == '0) go_paylen = 1'b1;
        else phase_next = PH_REPDATA;
      end
    end

    // payload length, explicit or implicit
    if (go_paylen && !fail_req) begin
      if (ltf_next[0]) begin
        if (lt_next != LT_WORD) begin
          fail_req = 1'b1; fail_code = asfd_pkg::ERR_HEADER;
        end else if (bleft_next < 16'd2) begin
          fail_req = 1'b1; fail_code = asfd_pkg::ERR_OVERRUN;
        end else begin
          phase_next = PH_PAYLEN; fcnt_next = '0; acc_next = '0;
        end
      end else if (pad_next > 32'(bleft_next)) begin
        fail_req = 1'b1; fail_code = asfd_pkg::ERR_LENGTH;
      end else begin
        pbl_next = 32'(bleft_next - pad_next[15:0]);
        go_delta = 1'b1;
      end
    end

    // optional time delta
    if (go_delta && !fail_req) begin
      if (rep_one_next) begin
        if (bleft_next == '0) begin
          fail_req = 1'b1; fail_code = asfd_pkg::ERR_OVERRUN;
        end else begin
          phase_next = PH_DELTA; fcnt_next = '0; acc_next = '0;
        end
      end else go_data = 1'b1;
    end

    // payload data start
    if (go_data && !fail_req) begin
      if (32'(bleft_next) < pbl_next) begin
        fail_req = 1'b1; fail_code = asfd_pkg::ERR_OVERRUN;
      end else if (pbl_next == '0) go_after = 1'b1;
      else phase_next = PH_DATA;
    end

    // next payload, trailing bytes or packet end
    if (go_after && !fail_req) begin
      if (pleft_next != '0) begin
        if (bleft_next == '0) begin
          fail_req = 1'b1; fail_code = asfd_pkg::ERR_OVERRUN;
        end else begin
          pleft_next = pleft_next - 1'b1; phase_next = PH_STREAM;
        end
      end else if (bleft_next != '0) begin
        pbl_next = 32'(bleft_next); is_audio_next = 1'b0; phase_next = PH_DATA;
      end else begin
        put_accept = (acount_next != '0);
        phase_next = PH_HDR;
      end
    end

    if (fail_req) begin
      err_next = 1'b1; phase_next = PH_HDR;
    end
  end

  // result assembly: audio byte first, then accept, end or error
  always_comb begin
    second = '0;
    if (fail_req) begin
      second.kind = asfd_pkg::KIND_ERROR; second.code = fail_code;
    end else if (put_accept) begin
      second.kind = asfd_pkg::KIND_ACCEPT; second.length = acount_next;
    end else if (put_end) begin
      second.kind = asfd_pkg::KIND_END;
    end
    res0 = '0;
    res1 = '0;
    if (put_audio) begin
      res0.kind = asfd_pkg::KIND_AUDIO; res0.payload = b;
      res1 = second;
    end else begin
      res0 = second;
    end
    push_n = 2'(put_audio) + 2'(fail_req | put_accept | put_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR;  fcnt <= '0;  acc <= '0;  ltf <= '0;  prop <= '0;
      pad <= '0;  bleft <= '0;  pleft <= '0;  pbl <= '0;  is_audio <= 1'b0;
      acount <= '0;  err <= 1'b0;  rep_one <= 1'b0;  lt <= '0;
    end else begin
      phase <= phase_next;  fcnt <= fcnt_next;  acc <= acc_next;
      ltf <= ltf_next;  prop <= prop_next;  pad <= pad_next;
      bleft <= bleft_next;  pleft <= pleft_next;  pbl <= pbl_next;
      is_audio <= is_audio_next;  acount <= acount_next;  err <= err_next;
      rep_one <= rep_one_next;  lt <= lt_next;
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst) err |=> err)
    else $error("error latch cleared without reset");
  a_err_silent: assert property (@(posedge clk) disable iff (rst) err |-> push_n == 2'd0)
    else $error("result produced after an error");
  a_err_idle_phase: assert property (@(posedge clk) disable iff (rst) err |-> phase == PH_HDR)
    else $error("parser left header phase after an error");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
      push_n != 2'd0 |-> take)
    else $error("results pushed without a transaction");
`endif

endmodule
